/* rtl/core/scba_pkg.sv */
package scba_pkg;

   // Geometry
   localparam int PAGE_BYTES    = 4096;
   localparam int CLASS_COUNT   = 9;
   localparam int REGION_STRIDE = 32768;
   localparam int WORD_BITS     = 64;

   localparam int MAX_SLOTS     = 512;
   localparam int UNIT_LOG_MIN  = 3;     // class 0 unit is 8 bytes

   // Field widths
   localparam int ADDR_W   = 32;
   localparam int SIZE_W   = 16;
   localparam int STATUS_W = 3;
   localparam int CNT_W    = 10;

   localparam int IDX_W     = $clog2(MAX_SLOTS);
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int MAX_WORDS = MAX_SLOTS / WORD_BITS;
   localparam int WIDX_W    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int WCNT_W    = WIDX_W + 1;
   localparam int CLS_W     = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
   localparam int SHIFT_W   = 4;

   // Commands
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] RSP_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] RSP_TOO_LARGE = 3'd1;
   localparam logic [STATUS_W-1:0] RSP_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] RSP_NOT_ALLOC = 3'd3;
   localparam logic [STATUS_W-1:0] RSP_UNKNOWN   = 3'd4;

   // Region of class k is PAGE_BYTES << order(k)
   function automatic int class_order(int k);
      int ord;
      case (k)
         0, 1:    ord = 0;
         2, 3:    ord = 1;
         4, 5:    ord = 2;
         default: ord = 3;
      endcase
      return ord;
   endfunction

   function automatic int cap_of(int k);
      int c;
      int lim;
      c   = (PAGE_BYTES << class_order(k)) >> (k + UNIT_LOG_MIN);
      lim = REGION_STRIDE >> (k + UNIT_LOG_MIN);
      if (c > lim) c = lim;
      if (c > MAX_SLOTS) c = MAX_SLOTS;
      return c;
   endfunction

   function automatic int words_of(int k);
      return (cap_of(k) + WORD_BITS - 1) >> BIT_W;
   endfunction

   function automatic int total_words();
      int t;
      t = 0;
      for (int k = 0; k < CLASS_COUNT; k++) t += words_of(k);
      return t;
   endfunction

   localparam int TOTAL_WORDS = total_words();
   localparam int RAM_AW      = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;

   typedef logic [CNT_W-1:0]  cnt_tbl_type   [CLASS_COUNT];
   typedef logic [WCNT_W-1:0] wcnt_tbl_type  [CLASS_COUNT];
   typedef logic [RAM_AW-1:0] waddr_tbl_type [CLASS_COUNT];
   typedef logic [ADDR_W-1:0] addr_tbl_type  [CLASS_COUNT];
   typedef logic [SIZE_W-1:0] size_tbl_type  [CLASS_COUNT];

   function automatic cnt_tbl_type build_cap_tbl();
      cnt_tbl_type t;
      for (int k = 0; k < CLASS_COUNT; k++) t[k] = CNT_W'(cap_of(k));
      return t;
   endfunction

   function automatic wcnt_tbl_type build_words_tbl();
      wcnt_tbl_type t;
      for (int k = 0; k < CLASS_COUNT; k++) t[k] = WCNT_W'(words_of(k));
      return t;
   endfunction

   function automatic waddr_tbl_type build_wbase_tbl();
      waddr_tbl_type t;
      int s;
      s = 0;
      for (int k = 0; k < CLASS_COUNT; k++) begin
         t[k] = RAM_AW'(s);
         s += words_of(k);
      end
      return t;
   endfunction

   function automatic addr_tbl_type build_span_tbl();
      addr_tbl_type t;
      for (int k = 0; k < CLASS_COUNT; k++)
         t[k] = ADDR_W'(cap_of(k) << (k + UNIT_LOG_MIN));
      return t;
   endfunction

   function automatic addr_tbl_type build_roff_tbl();
      addr_tbl_type t;
      for (int k = 0; k < CLASS_COUNT; k++) t[k] = ADDR_W'(k * REGION_STRIDE);
      return t;
   endfunction

   function automatic size_tbl_type build_unit_tbl();
      size_tbl_type t;
      for (int k = 0; k < CLASS_COUNT; k++) t[k] = SIZE_W'(1 << (k + UNIT_LOG_MIN));
      return t;
   endfunction

   localparam cnt_tbl_type   CAP_TBL   = build_cap_tbl();
   localparam wcnt_tbl_type  WORDS_TBL = build_words_tbl();
   localparam waddr_tbl_type WBASE_TBL = build_wbase_tbl();
   localparam addr_tbl_type  SPAN_TBL  = build_span_tbl();
   localparam addr_tbl_type  ROFF_TBL  = build_roff_tbl();
   localparam size_tbl_type  UNIT_TBL  = build_unit_tbl();

endpackage

/* rtl/core/scba_if.sv */
interface scba_req_if;
   logic                          valid;
   logic                          ready;
   logic                          command;
   logic [scba_pkg::SIZE_W-1:0]   request_size;
   logic [scba_pkg::ADDR_W-1:0]   object_address;

   modport source (output valid, command, request_size, object_address, input ready);
   modport sink   (input valid, command, request_size, object_address, output ready);
endinterface

interface scba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [scba_pkg::STATUS_W-1:0] status;
   logic [scba_pkg::ADDR_W-1:0]   granted_address;
   logic [scba_pkg::CNT_W-1:0]    class_free_count;

   modport source (output valid, status, granted_address, class_free_count, input ready);
   modport sink   (input valid, status, granted_address, class_free_count, output ready);
endinterface

interface scba_csr_if;
   logic                          valid;
   logic                          ready;
   logic [scba_pkg::ADDR_W-1:0]   pool_base;

   modport source (output valid, pool_base, input ready);
   modport sink   (input valid, pool_base, output ready);
endinterface

/* rtl/core/scba_adder.sv */
// Shared 32-bit add/subtract unit
module scba_adder (
   input  logic [scba_pkg::ADDR_W-1:0] op_a,
   input  logic [scba_pkg::ADDR_W-1:0] op_b,
   input  logic                        sub,
   output logic [scba_pkg::ADDR_W-1:0] sum
);

   assign sum = sub ? (op_a - op_b) : (op_a + op_b);

endmodule

/* rtl/core/scba_find_free.sv */
// Lowest clear bit of one bitmap word, ignoring bits past the class capacity
module scba_find_free (
   input  logic [scba_pkg::WORD_BITS-1:0] word,
   input  logic [scba_pkg::CNT_W-1:0]     limit,
   output logic                           found,
   output logic [scba_pkg::BIT_W-1:0]     bit_idx
);

   logic [scba_pkg::WORD_BITS-1:0] avail;

   always_comb begin
      for (int b = 0; b < scba_pkg::WORD_BITS; b++)
         avail[b] = !word[b] && (scba_pkg::CNT_W'(b) < limit);
      found   = |avail;
      bit_idx = '0;
      for (int b = scba_pkg::WORD_BITS - 1; b >= 0; b--)
         if (avail[b]) bit_idx = scba_pkg::BIT_W'(b);
   end

endmodule

/* rtl/core/scba_bitmap.sv */
// Occupancy bitmap store; per-word valid bits make unwritten words read as free
module scba_bitmap (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [scba_pkg::RAM_AW-1:0]    rd_addr,
   output logic [scba_pkg::WORD_BITS-1:0] rd_data,
   input  logic                           wr_en,
   input  logic [scba_pkg::RAM_AW-1:0]    wr_addr,
   input  logic [scba_pkg::WORD_BITS-1:0] wr_data
);

   logic [scba_pkg::WORD_BITS-1:0]   bitmap_mem [scba_pkg::TOTAL_WORDS];
   logic [scba_pkg::WORD_BITS-1:0]   rd_word_ff;
   logic                             rd_valid_ff;
   logic [scba_pkg::TOTAL_WORDS-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) bitmap_mem[wr_addr] <= wr_data;
      if (rd_en) rd_word_ff <= bitmap_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) valid_ff[wr_addr] <= 1'b1;
         if (rd_en) rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

/* rtl/core/size_class_bitmap_allocator.sv */
// Size-class bitmap allocator.
// req_bus (sink): command 0 allocates request_size bytes from the first of nine
//   power-of-two classes (8..2048 B) that fits; command 1 frees object_address.
// rsp_bus (source): one item per request: status, granted_address, and the
//   free slot count left in the touched class.
// csr_bus (sink): pool_base, always ready; write only while the block is idle.
// Sequence, accept to rsp valid:
//   allocate: scan the class bitmap words (1..8, class 0 worst),
//             one word per cycle from the bitmap store; a full class
//             goes to done after its last word, oversize goes straight to done.
//   free:     the shared adder walks the class regions (0..8) one per
//             cycle until one holds the address; if none does: unknown address.
// One request in flight: req ready is high only when the sequencer is idle.
// Result goes through an output register, so the next request is accepted
// while a result still waits; if rsp stalls, the following result waits in
// the done state and req stays low until the output register drains.
// Reset (synchronous): all slots free, free counts at class capacity,
// pool_base zero, no response pending. Bitmap clearing uses per-word valid
// bits, so no clearing pass is needed.
module size_class_bitmap_allocator (
   input  logic       clock,
   input  logic       reset,
   scba_req_if.sink   req_bus,
   scba_rsp_if.source rsp_bus,
   scba_csr_if.sink   csr_bus
);

   // Sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;   // alloc: test one bitmap word
   localparam logic [2:0] ST_GRANT  = 3'd2;   // alloc: region base + slot offset
   localparam logic [2:0] ST_LOCATE = 3'd3;   // free: find region of address
   localparam logic [2:0] ST_CHECK  = 3'd4;   // free: test and clear slot bit
   localparam logic [2:0] ST_DONE   = 3'd5;   // hand result to output register

   logic [2:0]                      state_ff, state_in;
   logic [scba_pkg::CLS_W-1:0]      k_ff, k_in;
   logic [scba_pkg::WIDX_W-1:0]     w_ff, w_in;
   logic [scba_pkg::ADDR_W-1:0]     acc_ff, acc_in;
   logic [scba_pkg::IDX_W-1:0]      idx_ff, idx_in;
   logic [scba_pkg::ADDR_W-1:0]     pool_base_ff;

   logic [scba_pkg::STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [scba_pkg::ADDR_W-1:0]     res_granted_ff, res_granted_in;
   logic [scba_pkg::CNT_W-1:0]      res_count_ff, res_count_in;

   logic [scba_pkg::CNT_W-1:0]      free_ff [scba_pkg::CLASS_COUNT];
   logic                            free_we;
   logic [scba_pkg::CNT_W-1:0]      free_wdata;

   logic                            rsp_valid_ff;
   logic [scba_pkg::STATUS_W-1:0]   rsp_status_ff;
   logic [scba_pkg::ADDR_W-1:0]     rsp_granted_ff;
   logic [scba_pkg::CNT_W-1:0]      rsp_count_ff;
   logic                            rsp_load;

   // Shared adder
   logic [scba_pkg::ADDR_W-1:0]     add_a, add_b, add_sum;
   logic                            add_sub;

   // Bitmap store
   logic                            rd_en, wr_en;
   logic [scba_pkg::RAM_AW-1:0]     rd_addr, wr_addr;
   logic [scba_pkg::WORD_BITS-1:0]  rd_data, wr_data;

   // Word scan
   logic [scba_pkg::CNT_W-1:0]      scan_limit;
   logic                            scan_found;
   logic [scba_pkg::BIT_W-1:0]      scan_bit;

   logic                            req_fire;
   logic                            sel_hit;
   logic [scba_pkg::CLS_W-1:0]      sel_k;
   logic [scba_pkg::SHIFT_W-1:0]    unit_shift;
   logic [scba_pkg::ADDR_W-1:0]     slot_off;
   logic                            loc_hit;
   logic [scba_pkg::IDX_W-1:0]      loc_idx;
   logic [scba_pkg::RAM_AW-1:0]     scan_waddr, slot_waddr;
   logic [scba_pkg::BIT_W-1:0]      slot_bit;
   logic [scba_pkg::CNT_W-1:0]      cur_free;

   scba_adder u_adder (
      .op_a (add_a),
      .op_b (add_b),
      .sub  (add_sub),
      .sum  (add_sum)
   );

   scba_bitmap u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   scba_find_free u_find (
      .word    (rd_data),
      .limit   (scan_limit),
      .found   (scan_found),
      .bit_idx (scan_bit)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   // First class whose unit holds the requested size
   always_comb begin
      sel_hit = 1'b0;
      sel_k   = '0;
      for (int k = scba_pkg::CLASS_COUNT - 1; k >= 0; k--)
         if (req_bus.request_size <= scba_pkg::UNIT_TBL[k]) begin
            sel_hit = 1'b1;
            sel_k   = scba_pkg::CLS_W'(k);
         end
   end

   // Per-class address arithmetic
   assign unit_shift = scba_pkg::SHIFT_W'(k_ff) + scba_pkg::SHIFT_W'(scba_pkg::UNIT_LOG_MIN);
   assign slot_off   = scba_pkg::ADDR_W'(idx_ff) << unit_shift;
   assign loc_hit    = acc_ff < scba_pkg::SPAN_TBL[k_ff];
   assign loc_idx    = scba_pkg::IDX_W'(acc_ff >> unit_shift);
   assign scan_limit = scba_pkg::CAP_TBL[k_ff]
                     - (scba_pkg::CNT_W'(w_ff) << scba_pkg::BIT_W);
   assign scan_waddr = scba_pkg::WBASE_TBL[k_ff] + scba_pkg::RAM_AW'(w_ff);
   assign slot_waddr = scba_pkg::WBASE_TBL[k_ff]
                     + scba_pkg::RAM_AW'(idx_ff[scba_pkg::IDX_W-1:scba_pkg::BIT_W]);
   assign slot_bit   = idx_ff[scba_pkg::BIT_W-1:0];
   assign cur_free   = free_ff[k_ff];

   // Adder operand selection
   always_comb begin
      add_a   = acc_ff;
      add_b   = '0;
      add_sub = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.command == scba_pkg::CMD_ALLOC) begin
               add_a = pool_base_ff;
               add_b = scba_pkg::ROFF_TBL[sel_k];
            end else begin
               add_a   = req_bus.object_address;
               add_b   = pool_base_ff;
               add_sub = 1'b1;
            end
         end
         ST_LOCATE: begin
            add_b   = scba_pkg::ADDR_W'(scba_pkg::REGION_STRIDE);
            add_sub = 1'b1;
         end
         ST_GRANT: add_b = slot_off;
         default: add_b = '0;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      k_in           = k_ff;
      w_in           = w_ff;
      acc_in         = acc_ff;
      idx_in         = idx_ff;
      res_status_in  = res_status_ff;
      res_granted_in = res_granted_ff;
      res_count_in   = res_count_ff;
      rd_en          = 1'b0;
      rd_addr        = scan_waddr;
      wr_en          = 1'b0;
      wr_addr        = slot_waddr;
      wr_data        = rd_data;
      free_we        = 1'b0;
      free_wdata     = cur_free;
      rsp_load       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               acc_in         = add_sum;
               res_granted_in = '0;
               res_count_in   = '0;
               if (req_bus.command == scba_pkg::CMD_FREE) begin
                  k_in     = '0;
                  state_in = ST_LOCATE;
               end else if (!sel_hit) begin
                  res_status_in = scba_pkg::RSP_TOO_LARGE;
                  state_in      = ST_DONE;
               end else begin
                  k_in     = sel_k;
                  w_in     = '0;
                  rd_en    = 1'b1;
                  rd_addr  = scba_pkg::WBASE_TBL[sel_k];
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_found) begin
               idx_in        = {w_ff, scan_bit};
               wr_en         = 1'b1;
               wr_addr       = scan_waddr;
               wr_data       = rd_data | (scba_pkg::WORD_BITS'(1) << scan_bit);
               free_we       = 1'b1;
               free_wdata    = cur_free - scba_pkg::CNT_W'(1);
               res_count_in  = cur_free - scba_pkg::CNT_W'(1);
               res_status_in = scba_pkg::RSP_OK;
               state_in      = ST_GRANT;
            end else if (scba_pkg::WCNT_W'(w_ff) + scba_pkg::WCNT_W'(1)
                         >= scba_pkg::WORDS_TBL[k_ff]) begin
               res_status_in = scba_pkg::RSP_FULL;
               state_in      = ST_DONE;
            end else begin
               w_in    = w_ff + scba_pkg::WIDX_W'(1);
               rd_en   = 1'b1;
               rd_addr = scan_waddr + scba_pkg::RAM_AW'(1);
            end
         end
         ST_GRANT: begin
            res_granted_in = add_sum;
            state_in       = ST_DONE;
         end
         ST_LOCATE: begin
            if (loc_hit) begin
               idx_in   = loc_idx;
               rd_en    = 1'b1;
               rd_addr  = scba_pkg::WBASE_TBL[k_ff]
                        + scba_pkg::RAM_AW'(loc_idx[scba_pkg::IDX_W-1:scba_pkg::BIT_W]);
               state_in = ST_CHECK;
            end else if (k_ff == scba_pkg::CLS_W'(scba_pkg::CLASS_COUNT - 1)) begin
               res_status_in = scba_pkg::RSP_UNKNOWN;
               state_in      = ST_DONE;
            end else begin
               acc_in = add_sum;
               k_in   = k_ff + scba_pkg::CLS_W'(1);
            end
         end
         ST_CHECK: begin
            if (!rd_data[slot_bit]) begin
               // double free: state untouched
               res_status_in = scba_pkg::RSP_NOT_ALLOC;
               res_count_in  = cur_free;
            end else begin
               wr_en   = 1'b1;
               wr_data = rd_data & ~(scba_pkg::WORD_BITS'(1) << slot_bit);
               free_we = 1'b1;
               if (cur_free < scba_pkg::CAP_TBL[k_ff])
                  free_wdata = cur_free + scba_pkg::CNT_W'(1);
               res_count_in  = free_wdata;
               res_status_in = scba_pkg::RSP_OK;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pool_base_ff <= '0;
         for (int k = 0; k < scba_pkg::CLASS_COUNT; k++)
            free_ff[k] <= scba_pkg::CAP_TBL[k];
      end else begin
         state_ff <= state_in;
         if (csr_bus.valid) pool_base_ff <= csr_bus.pool_base;
         if (free_we) free_ff[k_ff] <= free_wdata;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_bus.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      k_ff           <= k_in;
      w_ff           <= w_in;
      acc_ff         <= acc_in;
      idx_ff         <= idx_in;
      res_status_ff  <= res_status_in;
      res_granted_ff <= res_granted_in;
      res_count_ff   <= res_count_in;
      if (rsp_load) begin
         rsp_status_ff  <= res_status_ff;
         rsp_granted_ff <= res_granted_ff;
         rsp_count_ff   <= res_count_ff;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.status           = rsp_status_ff;
   assign rsp_bus.granted_address  = rsp_granted_ff;
   assign rsp_bus.class_free_count = rsp_count_ff;

`ifndef SYNTHESIS
   // an accepted request always leaves the sequencer busy in the cycle after
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("request accepted but sequencer stayed idle");

   // scan never runs past the last bitmap word of the class
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scba_pkg::WCNT_W'(w_ff) < scba_pkg::WORDS_TBL[k_ff]))
      else $error("bitmap scan beyond class words");

   // a granted slot leaves the class count below capacity
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GRANT) |-> (free_ff[k_ff] < scba_pkg::CAP_TBL[k_ff]))
      else $error("free count not below capacity after allocate");

   // failed operations never report an address
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.status != scba_pkg::RSP_OK))
         |-> (rsp_bus.granted_address == '0))
      else $error("nonzero address on failed response");
`endif

endmodule

/* verif/size_class_bitmap_allocator_tb.sv */
`timescale 1ns / 1ps

module size_class_bitmap_allocator_tb;

   // One result item as the block returns it
   typedef struct packed {
      logic [scba_pkg::STATUS_W-1:0] status;
      logic [scba_pkg::ADDR_W-1:0]   granted_address;
      logic [scba_pkg::CNT_W-1:0]    class_free_count;
   } outcome_type;

   logic clock;
   logic reset;

   scba_req_if req_bus ();
   scba_rsp_if rsp_bus ();
   scba_csr_if csr_bus ();

   size_class_bitmap_allocator u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Shadow of the allocator: occupancy per class, free counts, pool base
   bit [scba_pkg::MAX_SLOTS-1:0] used_map  [scba_pkg::CLASS_COUNT];
   int unsigned                  free_left [scba_pkg::CLASS_COUNT];
   logic [scba_pkg::ADDR_W-1:0]  pool_base_q;

   // Outcomes predicted at accept time, oldest first
   outcome_type pending_outcomes [$];
   int          mismatch_count = 0;

   // Random idling on both sides when set; back to back when clear
   bit pace_random = 1'b1;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // Geometry of the size classes
   // ---------------------------------------------------------------------
   function automatic logic [scba_pkg::ADDR_W-1:0] unit_bytes(int k);
      return scba_pkg::ADDR_W'(8) << k;
   endfunction

   // Region is one page shifted by the class order (0,0,1,1,2,2,3,3,3),
   // clipped to the stride and to what the counters hold.
   function automatic int slots_per_class(int k);
      int ord;
      int cap;
      int lim;
      ord = ((k >> 1) > 3) ? 3 : (k >> 1);
      cap = (scba_pkg::PAGE_BYTES << ord) / (8 << k);
      lim = scba_pkg::REGION_STRIDE / (8 << k);
      if (cap > lim) cap = lim;
      if (cap > scba_pkg::MAX_SLOTS) cap = scba_pkg::MAX_SLOTS;
      return cap;
   endfunction

   // All address math wraps at 32 bits
   function automatic logic [scba_pkg::ADDR_W-1:0] class_base(int k);
      return pool_base_q + scba_pkg::ADDR_W'(k * scba_pkg::REGION_STRIDE);
   endfunction

   function automatic logic [scba_pkg::ADDR_W-1:0] slot_address(int k, int idx);
      return class_base(k) + scba_pkg::ADDR_W'(idx) * unit_bytes(k);
   endfunction

   // ---------------------------------------------------------------------
   // Predictor: applies one request to the shadow state, returns the item
   // ---------------------------------------------------------------------
   function automatic outcome_type allocator_outcome(
      logic                        cmd,
      logic [scba_pkg::SIZE_W-1:0] size_req,
      logic [scba_pkg::ADDR_W-1:0] addr);
      outcome_type                 o;
      int                          k;
      int                          idx;
      int                          cap;
      int                          hit;
      logic [scba_pkg::ADDR_W-1:0] off;
      o.status           = scba_pkg::RSP_OK;
      o.granted_address  = '0;
      o.class_free_count = '0;
      hit                = -1;
      if (cmd == scba_pkg::CMD_ALLOC) begin
         // smallest class whose unit covers the size; size 0 lands in class 0
         for (k = scba_pkg::CLASS_COUNT - 1; k >= 0; k--)
            if (scba_pkg::ADDR_W'(size_req) <= unit_bytes(k)) hit = k;
         if (hit < 0) begin
            o.status = scba_pkg::RSP_TOO_LARGE;
         end else begin
            cap = slots_per_class(hit);
            idx = -1;
            for (k = cap - 1; k >= 0; k--)
               if (!used_map[hit][k]) idx = k;
            if (idx < 0 || free_left[hit] == 0) begin
               o.status = scba_pkg::RSP_FULL;
            end else begin
               used_map[hit][idx] = 1'b1;
               free_left[hit]--;
               o.granted_address  = slot_address(hit, idx);
               o.class_free_count = scba_pkg::CNT_W'(free_left[hit]);
            end
         end
      end else begin
         // first class whose slot span holds the address, in class order
         o.status = scba_pkg::RSP_UNKNOWN;
         for (k = 0; k < scba_pkg::CLASS_COUNT; k++) begin
            off = addr - class_base(k);
            if (hit < 0 && off < scba_pkg::ADDR_W'(slots_per_class(k)) * unit_bytes(k))
               hit = k;
         end
         if (hit >= 0) begin
            cap = slots_per_class(hit);
            off = addr - class_base(hit);
            idx = int'(off / unit_bytes(hit));      // any byte of a slot hits it
            if (!used_map[hit][idx]) begin
               o.status = scba_pkg::RSP_NOT_ALLOC;   // double free, state kept
            end else begin
               used_map[hit][idx] = 1'b0;
               if (free_left[hit] < cap) free_left[hit]++;
               o.status = scba_pkg::RSP_OK;
            end
            o.class_free_count = scba_pkg::CNT_W'(free_left[hit]);
         end
      end
      return o;
   endfunction

   function automatic bit classes_in_use();
      bit any;
      any = 1'b0;
      for (int k = 0; k < scba_pkg::CLASS_COUNT; k++)
         if (free_left[k] != slots_per_class(k)) any = 1'b1;
      return any;
   endfunction

   // Random class and slot that currently hold an object (caller checks one exists)
   function automatic void pick_live_slot(output int k, output int idx);
      int first;
      int cap;
      int j;
      k = $urandom_range(0, scba_pkg::CLASS_COUNT - 1);
      for (j = 0; j < scba_pkg::CLASS_COUNT && free_left[k] == slots_per_class(k); j++)
         k = (k + 1) % scba_pkg::CLASS_COUNT;
      cap   = slots_per_class(k);
      first = $urandom_range(0, cap - 1);
      idx   = first;
      for (j = 0; j < cap && !used_map[k][idx]; j++)
         idx = (idx + 1) % cap;
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int idle_gap();
      int r;
      if (!pace_random) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   // Valid stays high across back-to-back items: one assignment per edge.
   task automatic send_request(input logic cmd, input logic [scba_pkg::SIZE_W-1:0] size_req,
                               input logic [scba_pkg::ADDR_W-1:0] addr);
      int gap;
      gap = idle_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.command        <= cmd;
      req_bus.request_size   <= size_req;
      req_bus.object_address <= addr;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_outcomes.push_back(allocator_outcome(cmd, size_req, addr));
   endtask

   // Quiesce: stop requests, wait for every result, then wait out the slowest
   // request (an unknown address walks all classes).
   task automatic drain_outstanding();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_pool_base(input logic [scba_pkg::ADDR_W-1:0] value);
      @(negedge clock);
      csr_bus.valid     <= 1'b1;
      csr_bus.pool_base <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      pool_base_q = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Result side back-pressure: short stalls, now and then a long one
   initial begin
      int hold;
      hold = 0;
      rsp_bus.ready <= 1'b1;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            hold--;
         end else if (pace_random && $urandom_range(0, 99) < 20) begin
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 2);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result checker: every accepted item against the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: result with nothing expected: status %0d address %h count %0d",
                     $time, rsp_bus.status, rsp_bus.granted_address, rsp_bus.class_free_count);
            mismatch_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_bus.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_bus.status);
               mismatch_count++;
            end
            if (rsp_bus.granted_address !== want.granted_address) begin
               $display("%0t: granted_address expected %h actual %h",
                        $time, want.granted_address, rsp_bus.granted_address);
               mismatch_count++;
            end
            if (rsp_bus.class_free_count !== want.class_free_count) begin
               $display("%0t: class_free_count expected %0d actual %0d",
                        $time, want.class_free_count, rsp_bus.class_free_count);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Size to class mapping at the edges, oversize codes
   task automatic test_alloc_sizes();
      write_pool_base('0);
      send_request(scba_pkg::CMD_ALLOC, 16'd0, $urandom);     // zero size, class 0 slot 0
      send_request(scba_pkg::CMD_ALLOC, 16'd8, $urandom);     // exact unit, class 0 slot 1
      send_request(scba_pkg::CMD_ALLOC, 16'd9, $urandom);     // one over, class 1
      send_request(scba_pkg::CMD_ALLOC, 16'd2048, $urandom);  // largest class
      send_request(scba_pkg::CMD_ALLOC, 16'd2049, $urandom);  // just too large
      send_request(scba_pkg::CMD_ALLOC, 16'hFFFF, $urandom);  // all ones
   endtask

   // Free by interior byte, double free, addresses outside every region
   task automatic test_free_paths();
      send_request(scba_pkg::CMD_FREE, $urandom, 32'h0000_0007); // last byte of class 0 slot 0
      send_request(scba_pkg::CMD_FREE, $urandom, 32'h0000_0003); // same slot again
      send_request(scba_pkg::CMD_FREE, 16'hFFFF, 32'hFFFF_FFFF); // above every region
      send_request(scba_pkg::CMD_FREE, 16'h0000, 32'h0000_1000); // one past class 0 span
   endtask

   // Class 8 region straddles address zero: fill it, overflow it,
   // free the slot that wrapped to zero and take it back.
   task automatic test_full_class_wrap();
      drain_outstanding();
      write_pool_base(32'hFFFB_C000);
      repeat (15)
         send_request(scba_pkg::CMD_ALLOC,
                      scba_pkg::SIZE_W'($urandom_range(1025, 2048)), $urandom);
      send_request(scba_pkg::CMD_ALLOC, 16'd2048, $urandom);  // class full
      send_request(scba_pkg::CMD_FREE, $urandom, 32'h0000_07FF);
      send_request(scba_pkg::CMD_ALLOC, 16'd1025, $urandom);
   endtask

   // Mostly well-formed alloc/free traffic, with a tail of bad frees,
   // oversize requests and fully random items.
   task automatic test_random_traffic(input int count, input logic [scba_pkg::ADDR_W-1:0] base,
                                      input int alloc_pct, input bit fill_small,
                                      input bit paced);
      int                          n;
      int                          pick;
      int                          k;
      int                          idx;
      logic [scba_pkg::SIZE_W-1:0] size_req;
      logic [scba_pkg::ADDR_W-1:0] addr;
      drain_outstanding();
      write_pool_base(base);
      pace_random = paced;
      for (n = 0; n < count; n++) begin
         pick     = $urandom_range(0, 99);
         size_req = $urandom;
         addr     = $urandom;
         if (pick >= alloc_pct && pick < 80 && !classes_in_use()) pick = 0;
         if (pick < alloc_pct) begin
            // class 0 bias pushes the scan past the first bitmap words
            if (fill_small && $urandom_range(0, 99) < 40) k = 0;
            else k = $urandom_range(0, scba_pkg::CLASS_COUNT - 1);
            size_req = (k == 0) ? scba_pkg::SIZE_W'($urandom_range(0, 8))
                                : scba_pkg::SIZE_W'($urandom_range((4 << k) + 1, 8 << k));
            send_request(scba_pkg::CMD_ALLOC, size_req, addr);
         end else if (pick < 80) begin
            pick_live_slot(k, idx);
            send_request(scba_pkg::CMD_FREE, size_req,
                         slot_address(k, idx)
                         + scba_pkg::ADDR_W'($urandom_range(0, (8 << k) - 1)));
         end else if (pick < 88) begin
            // any slot, live or not: double frees show up here
            k   = $urandom_range(0, scba_pkg::CLASS_COUNT - 1);
            idx = $urandom_range(0, slots_per_class(k) - 1);
            send_request(scba_pkg::CMD_FREE, size_req,
                         slot_address(k, idx)
                         + scba_pkg::ADDR_W'($urandom_range(0, (8 << k) - 1)));
         end else if (pick < 93) begin
            send_request(scba_pkg::CMD_ALLOC,
                         scba_pkg::SIZE_W'($urandom_range(2049, 65535)), addr);
         end else if (pick < 97) begin
            send_request(scba_pkg::CMD_FREE, size_req, addr);
         end else begin
            send_request(logic'($urandom_range(0, 1)), size_req, addr);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.command        <= scba_pkg::CMD_ALLOC;
      req_bus.request_size   <= '0;
      req_bus.object_address <= '0;
      csr_bus.valid          <= 1'b0;
      csr_bus.pool_base      <= '0;
      pool_base_q = '0;
      for (int k = 0; k < scba_pkg::CLASS_COUNT; k++) begin
         used_map[k]  = '0;
         free_left[k] = slots_per_class(k);
      end
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      test_alloc_sizes();
      test_free_paths();
      test_full_class_wrap();
      // top of the address space, no idling on either side
      test_random_traffic(300, 32'hFFFF_FFFF, 45, 1'b0, 1'b0);
      // random base, allocate heavy to fill classes deep
      test_random_traffic(320, $urandom, 70, 1'b1, 1'b1);
      // base zero, free heavy to drain
      test_random_traffic(300, 32'h0000_0000, 30, 1'b0, 1'b1);

      drain_outstanding();
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog, well above the slowest legal run
   initial begin
      #4_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
